// ===== src/tcb_pkg.sv =====
package tcb_pkg;

  // Cycle costs reported with each result
  localparam logic [3:0] BRANCH_CYCLES = 4'd3;
  localparam logic [3:0] LINK_CYCLES   = 4'd4;
  localparam logic [3:0] BASE_CYCLES   = 4'd1;

  // Top nibble of an exception-return address
  localparam logic [3:0] EXC_RETURN_NIBBLE = 4'hF;

  typedef enum logic [3:0] {
    REQ_CMN     = 4'd0,
    REQ_CMP_IMM = 4'd1,
    REQ_CMP_REG = 4'd2,
    REQ_TST     = 4'd3,
    REQ_B       = 4'd4,
    REQ_B_COND  = 4'd5,
    REQ_BLX     = 4'd6,
    REQ_BX      = 4'd7,
    REQ_BL      = 4'd8
  } req_e;

  typedef enum logic [3:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13
  } cond_e;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_COND      = 2'd1,
    FAULT_INTERWORK = 2'd2
  } fault_e;

  // Flags: N, Z, C, V from msb to lsb
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } nzcv_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [23:0] immediate;
    logic [3:0]  condition;
    logic [31:0] pc_value;
  } req_t;

  typedef struct packed {
    nzcv_t       flags;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        link_write;
    logic [31:0] link_value;
    logic        exception_return;
    logic [1:0]  fault;
    logic [3:0]  cycles;
  } res_t;

endpackage

// ===== src/tcb_exec.sv =====
module tcb_exec (
  input  tcb_pkg::req_t  req_i,
  input  tcb_pkg::nzcv_t flags_i,
  output tcb_pkg::nzcv_t flags_o,
  output tcb_pkg::res_t  res_o
);

  logic [31:0] add_b;
  logic        add_cin;
  logic [32:0] add_sum;
  logic [31:0] add_res;
  logic [31:0] tst_res;
  logic [31:0] off_b;
  logic [31:0] off_bc;
  logic [31:0] off_bl;
  logic        cond_ok;
  tcb_pkg::nzcv_t arith_flags;

  // CMP adds the complement of the second operand plus one; CMN adds it as is
  always_comb begin
    add_b   = req_i.operand_b;
    add_cin = 1'b1;
    case (tcb_pkg::req_e'(req_i.req_type))
      tcb_pkg::REQ_CMN: begin
        add_b   = req_i.operand_b;
        add_cin = 1'b0;
      end
      tcb_pkg::REQ_CMP_IMM: add_b = ~{8'd0, req_i.immediate};
      default:              add_b = ~req_i.operand_b;
    endcase
  end

  assign add_sum = {1'b0, req_i.operand_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_res = add_sum[31:0];
  assign tst_res = req_i.operand_a & req_i.operand_b;

  assign arith_flags.n = add_res[31];
  assign arith_flags.z = (add_res == 32'd0);
  assign arith_flags.c = add_sum[32];
  assign arith_flags.v = ~(req_i.operand_a[31] ^ add_b[31]) & (req_i.operand_a[31] ^ add_res[31]);

  // Halfword offsets, sign extended
  assign off_b  = {{20{req_i.immediate[10]}}, req_i.immediate[10:0], 1'b0};
  assign off_bc = {{23{req_i.immediate[7]}}, req_i.immediate[7:0], 1'b0};
  assign off_bl = {{7{req_i.immediate[23]}}, req_i.immediate[23:0], 1'b0};

  always_comb begin
    case (tcb_pkg::cond_e'(req_i.condition))
      tcb_pkg::COND_EQ: cond_ok = flags_i.z;
      tcb_pkg::COND_NE: cond_ok = ~flags_i.z;
      tcb_pkg::COND_CS: cond_ok = flags_i.c;
      tcb_pkg::COND_CC: cond_ok = ~flags_i.c;
      tcb_pkg::COND_MI: cond_ok = flags_i.n;
      tcb_pkg::COND_PL: cond_ok = ~flags_i.n;
      tcb_pkg::COND_VS: cond_ok = flags_i.v;
      tcb_pkg::COND_VC: cond_ok = ~flags_i.v;
      tcb_pkg::COND_HI: cond_ok = flags_i.c & ~flags_i.z;
      tcb_pkg::COND_LS: cond_ok = flags_i.z | ~flags_i.c;
      tcb_pkg::COND_GE: cond_ok = (flags_i.n == flags_i.v);
      tcb_pkg::COND_LT: cond_ok = (flags_i.n != flags_i.v);
      tcb_pkg::COND_GT: cond_ok = ~flags_i.z & (flags_i.n == flags_i.v);
      tcb_pkg::COND_LE: cond_ok = flags_i.z | (flags_i.n != flags_i.v);
      default:          cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    flags_o                = flags_i;
    res_o.branch_taken     = 1'b0;
    res_o.next_pc          = req_i.pc_value;
    res_o.link_write       = 1'b0;
    res_o.link_value       = 32'd0;
    res_o.exception_return = 1'b0;
    res_o.fault            = tcb_pkg::FAULT_NONE;
    res_o.cycles           = tcb_pkg::BASE_CYCLES;
    case (tcb_pkg::req_e'(req_i.req_type))
      tcb_pkg::REQ_CMN,
      tcb_pkg::REQ_CMP_IMM,
      tcb_pkg::REQ_CMP_REG: flags_o = arith_flags;
      tcb_pkg::REQ_TST: begin
        flags_o.n = tst_res[31];
        flags_o.z = (tst_res == 32'd0);
      end
      tcb_pkg::REQ_B: begin
        res_o.branch_taken = 1'b1;
        res_o.next_pc      = req_i.pc_value + off_b;
        res_o.cycles       = tcb_pkg::BRANCH_CYCLES;
      end
      tcb_pkg::REQ_B_COND: begin
        if (req_i.condition > tcb_pkg::COND_LE) begin
          res_o.fault = tcb_pkg::FAULT_COND;
        end else if (cond_ok) begin
          res_o.branch_taken = 1'b1;
          res_o.next_pc      = req_i.pc_value + off_bc;
          res_o.cycles       = tcb_pkg::BRANCH_CYCLES;
        end
      end
      tcb_pkg::REQ_BLX: begin
        if (!req_i.operand_a[0]) begin
          res_o.fault = tcb_pkg::FAULT_INTERWORK;
        end else begin
          res_o.branch_taken = 1'b1;
          res_o.next_pc      = req_i.operand_a;
          res_o.link_write   = 1'b1;
          res_o.link_value   = req_i.pc_value - 32'd2;
          res_o.cycles       = tcb_pkg::BRANCH_CYCLES;
        end
      end
      tcb_pkg::REQ_BX: begin
        if (!req_i.operand_a[0]) begin
          res_o.fault = tcb_pkg::FAULT_INTERWORK;
        end else begin
          res_o.branch_taken     = 1'b1;
          res_o.next_pc          = req_i.operand_a;
          res_o.exception_return = (req_i.operand_a[31:28] == tcb_pkg::EXC_RETURN_NIBBLE);
          res_o.cycles           = tcb_pkg::BRANCH_CYCLES;
        end
      end
      tcb_pkg::REQ_BL: begin
        res_o.branch_taken = 1'b1;
        res_o.next_pc      = req_i.pc_value + off_bl;
        res_o.link_write   = 1'b1;
        res_o.link_value   = req_i.pc_value;
        res_o.cycles       = tcb_pkg::LINK_CYCLES;
      end
      default: begin
      end
    endcase
    res_o.flags = flags_o;
  end

endmodule

// ===== src/thumb_compare_branch_unit.sv =====
// Thumb compare and branch execute unit. Each transfer on the input channel
// carries one decoded compare (CMN, CMP, TST) or branch (B, B<cond>, BL, BLX,
// BX) and yields exactly one result transfer: the NZCV flags after the
// instruction, the next PC, the link write, the exception-return request,
// a fault code and the cycle cost. The unit takes one instruction per cycle
// while its input is not stalled. An instruction waits in the input register
// and is then executed into the result register, from which its result is
// offered on the output. The result transfers at an edge where the output
// is not stalled. The flag register is updated as an instruction moves from
// the input register to the result register. A conditional branch directly
// behind a compare therefore sees the new flags. Flags reset to zero.
module thumb_compare_branch_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  req_type_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [23:0] immediate_i,
  input  logic [3:0]  condition_i,
  input  logic [31:0] pc_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        flag_c_o,
  output logic        flag_v_o,
  output logic        branch_taken_o,
  output logic [31:0] next_pc_o,
  output logic        link_write_o,
  output logic [31:0] link_value_o,
  output logic        exception_return_o,
  output logic [1:0]  fault_o,
  output logic [3:0]  cycles_o
);

  logic           in_valid_q;
  tcb_pkg::req_t  req_q;
  logic           out_valid_q;
  tcb_pkg::res_t  res_q;
  tcb_pkg::res_t  res_d;
  tcb_pkg::nzcv_t flags_q;
  tcb_pkg::nzcv_t flags_d;
  logic           out_free;
  logic           exec_fire;
  logic           in_fire;

  // The result register is free when empty or when its transfer completes now
  assign out_free   = ~out_valid_q | ~out_stall_i;
  // Move the held instruction into the result register
  assign exec_fire  = in_valid_q & out_free;
  // Hold the input side only while the input register cannot advance
  assign in_stall_o = in_valid_q & ~out_free;
  assign in_fire    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= '{req_type:  req_type_i,
                 operand_a: operand_a_i,
                 operand_b: operand_b_i,
                 immediate: immediate_i,
                 condition: condition_i,
                 pc_value:  pc_value_i};
    end
  end

  tcb_exec u_exec (
    .req_i   (req_q),
    .flags_i (flags_q),
    .flags_o (flags_d),
    .res_o   (res_d)
  );

  // Advance the architectural flags only when the instruction retires here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (exec_fire) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign flag_n_o           = res_q.flags.n;
  assign flag_z_o           = res_q.flags.z;
  assign flag_c_o           = res_q.flags.c;
  assign flag_v_o           = res_q.flags.v;
  assign branch_taken_o     = res_q.branch_taken;
  assign next_pc_o          = res_q.next_pc;
  assign link_write_o       = res_q.link_write;
  assign link_value_o       = res_q.link_value;
  assign exception_return_o = res_q.exception_return;
  assign fault_o            = res_q.fault;
  assign cycles_o           = res_q.cycles;

endmodule

// ===== src/tcb_checker.sv =====
module tcb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        branch_taken_o,
  input logic [31:0] next_pc_o,
  input logic        link_write_o,
  input logic [31:0] link_value_o,
  input logic        exception_return_o,
  input logic [1:0]  fault_o,
  input logic [3:0]  cycles_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o)
      && $stable(cycles_o) && $stable(fault_o) && $stable(branch_taken_o))
    else $error("stalled result changed");

  // A faulted instruction never redirects
  a_fault_no_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fault_o != tcb_pkg::FAULT_NONE) |->
      !branch_taken_o && !link_write_o && !exception_return_o
      && (cycles_o == tcb_pkg::BASE_CYCLES))
    else $error("fault with side effects");

  // Link writes only come with a taken branch
  a_link_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_write_o |-> branch_taken_o && !exception_return_o)
    else $error("link write without branch");

  // Cycle cost follows the kind of redirect
  a_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (!branch_taken_o && cycles_o == tcb_pkg::BASE_CYCLES && link_value_o == 32'd0)
      || (branch_taken_o && !link_write_o && cycles_o == tcb_pkg::BRANCH_CYCLES)
      || (branch_taken_o && link_write_o
          && (cycles_o == tcb_pkg::BRANCH_CYCLES || cycles_o == tcb_pkg::LINK_CYCLES)))
    else $error("cycle cost mismatch");

  // Exception return targets the magic address range
  a_exc_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exception_return_o |->
      branch_taken_o && (next_pc_o[31:28] == tcb_pkg::EXC_RETURN_NIBBLE) && next_pc_o[0])
    else $error("bad exception return");

endmodule

bind thumb_compare_branch_unit tcb_checker u_tcb_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ITEMS_PER_PHASE = 417;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned HOLD_CYCLES     = 60;
  localparam int unsigned DRAIN_CYCLES    = 20;

  // Unit that predicts every result from the accepted instructions and keeps the
  // stored NZCV flags in step with the block.
  class exec_scoreboard;
    tcb_pkg::nzcv_t nzcv;
    tcb_pkg::res_t  predicted_q[$];
    int unsigned    mismatches;
    int unsigned    retired;
    int unsigned    taken_cnt;
    int unsigned    fault_cnt;
    int unsigned    exc_ret_cnt;
    int unsigned    link_cnt;

    function new();
      nzcv        = '0;
      mismatches  = 0;
      retired     = 0;
      taken_cnt   = 0;
      fault_cnt   = 0;
      exc_ret_cnt = 0;
      link_cnt    = 0;
    endfunction

    // Adder flags: CMP adds the complement of the second operand plus one, CMN adds it as is.
    function void add_flags(logic [31:0] x, logic [31:0] y, logic cin);
      logic [32:0] wide;
      wide   = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      nzcv.n = wide[31];
      nzcv.z = (wide[31:0] == 32'd0);
      nzcv.c = wide[32];
      nzcv.v = ~(x[31] ^ y[31]) & (x[31] ^ wide[31]);
    endfunction

    function logic cond_met(logic [3:0] c);
      case (c)
        tcb_pkg::COND_EQ: return nzcv.z;
        tcb_pkg::COND_NE: return !nzcv.z;
        tcb_pkg::COND_CS: return nzcv.c;
        tcb_pkg::COND_CC: return !nzcv.c;
        tcb_pkg::COND_MI: return nzcv.n;
        tcb_pkg::COND_PL: return !nzcv.n;
        tcb_pkg::COND_VS: return nzcv.v;
        tcb_pkg::COND_VC: return !nzcv.v;
        tcb_pkg::COND_HI: return nzcv.c && !nzcv.z;
        tcb_pkg::COND_LS: return nzcv.z || !nzcv.c;
        tcb_pkg::COND_GE: return nzcv.n == nzcv.v;
        tcb_pkg::COND_LT: return nzcv.n != nzcv.v;
        tcb_pkg::COND_GT: return !nzcv.z && (nzcv.n == nzcv.v);
        default:          return nzcv.z || (nzcv.n != nzcv.v);
      endcase
    endfunction

    // Execute one instruction against the local flag copy.
    function tcb_pkg::res_t execute_insn(tcb_pkg::req_t r);
      tcb_pkg::res_t res;
      logic [31:0]   tst_and;
      res.branch_taken     = 1'b0;
      res.next_pc          = r.pc_value;
      res.link_write       = 1'b0;
      res.link_value       = 32'd0;
      res.exception_return = 1'b0;
      res.fault            = tcb_pkg::FAULT_NONE;
      res.cycles           = tcb_pkg::BASE_CYCLES;
      case (r.req_type)
        tcb_pkg::REQ_CMN:     add_flags(r.operand_a, r.operand_b, 1'b0);
        tcb_pkg::REQ_CMP_IMM: add_flags(r.operand_a, ~{8'd0, r.immediate}, 1'b1);
        tcb_pkg::REQ_CMP_REG: add_flags(r.operand_a, ~r.operand_b, 1'b1);
        tcb_pkg::REQ_TST: begin
          // keep C and V
          tst_and = r.operand_a & r.operand_b;
          nzcv.n  = tst_and[31];
          nzcv.z  = (tst_and == 32'd0);
        end
        tcb_pkg::REQ_B: begin
          res.branch_taken = 1'b1;
          res.next_pc      = r.pc_value + {{20{r.immediate[10]}}, r.immediate[10:0], 1'b0};
          res.cycles       = tcb_pkg::BRANCH_CYCLES;
        end
        tcb_pkg::REQ_B_COND: begin
          if (r.condition > tcb_pkg::COND_LE) begin
            res.fault = tcb_pkg::FAULT_COND;
          end else if (cond_met(r.condition)) begin
            res.branch_taken = 1'b1;
            res.next_pc      = r.pc_value + {{23{r.immediate[7]}}, r.immediate[7:0], 1'b0};
            res.cycles       = tcb_pkg::BRANCH_CYCLES;
          end
        end
        tcb_pkg::REQ_BLX, tcb_pkg::REQ_BX: begin
          if (!r.operand_a[0]) begin
            res.fault = tcb_pkg::FAULT_INTERWORK;
          end else begin
            res.branch_taken = 1'b1;
            res.next_pc      = r.operand_a;
            res.cycles       = tcb_pkg::BRANCH_CYCLES;
            if (r.req_type == tcb_pkg::REQ_BLX) begin
              res.link_write = 1'b1;
              res.link_value = r.pc_value - 32'd2;
            end else begin
              res.exception_return = (r.operand_a[31:28] == tcb_pkg::EXC_RETURN_NIBBLE);
            end
          end
        end
        tcb_pkg::REQ_BL: begin
          res.branch_taken = 1'b1;
          res.next_pc      = r.pc_value + {{7{r.immediate[23]}}, r.immediate, 1'b0};
          res.link_write   = 1'b1;
          res.link_value   = r.pc_value;
          res.cycles       = tcb_pkg::LINK_CYCLES;
        end
        default: ;
      endcase
      res.flags = nzcv;
      return res;
    endfunction

    function void note_insn(tcb_pkg::req_t r);
      predicted_q.push_back(execute_insn(r));
    endfunction

    function void diff(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(tcb_pkg::res_t got);
      tcb_pkg::res_t want;
      if (predicted_q.size() == 0) begin
        $error("result transfer with nothing predicted");
        mismatches++;
        return;
      end
      want = predicted_q.pop_front();
      diff("flag_n", 32'(want.flags.n), 32'(got.flags.n));
      diff("flag_z", 32'(want.flags.z), 32'(got.flags.z));
      diff("flag_c", 32'(want.flags.c), 32'(got.flags.c));
      diff("flag_v", 32'(want.flags.v), 32'(got.flags.v));
      diff("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
      diff("next_pc", want.next_pc, got.next_pc);
      diff("link_write", 32'(want.link_write), 32'(got.link_write));
      diff("link_value", want.link_value, got.link_value);
      diff("exception_return", 32'(want.exception_return), 32'(got.exception_return));
      diff("fault", 32'(want.fault), 32'(got.fault));
      diff("cycles", 32'(want.cycles), 32'(got.cycles));
      retired++;
      if (want.branch_taken) taken_cnt++;
      if (want.fault != tcb_pkg::FAULT_NONE) fault_cnt++;
      if (want.exception_return) exc_ret_cnt++;
      if (want.link_write) link_cnt++;
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [3:0]  req_type_i  = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic [23:0] immediate_i = '0;
  logic [3:0]  condition_i = '0;
  logic [31:0] pc_value_i  = '0;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        flag_n_o;
  logic        flag_z_o;
  logic        flag_c_o;
  logic        flag_v_o;
  logic        branch_taken_o;
  logic [31:0] next_pc_o;
  logic        link_write_o;
  logic [31:0] link_value_o;
  logic        exception_return_o;
  logic [1:0]  fault_o;
  logic [3:0]  cycles_o;

  // Idle rates in percent; the sender's is only used by the driving process.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // Request for one long hold-off on the result side.
  logic        hold_req    = 1'b0;
  int unsigned cycle_cnt   = 0;

  exec_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  thumb_compare_branch_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .operand_a_i        (operand_a_i),
    .operand_b_i        (operand_b_i),
    .immediate_i        (immediate_i),
    .condition_i        (condition_i),
    .pc_value_i         (pc_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .flag_n_o           (flag_n_o),
    .flag_z_o           (flag_z_o),
    .flag_c_o           (flag_c_o),
    .flag_v_o           (flag_v_o),
    .branch_taken_o     (branch_taken_o),
    .next_pc_o          (next_pc_o),
    .link_write_o       (link_write_o),
    .link_value_o       (link_value_o),
    .exception_return_o (exception_return_o),
    .fault_o            (fault_o),
    .cycles_o           (cycles_o)
  );

  // Watchdog: end the run if the stimulus or the drain hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side stall. Once hold_req goes high, hold the output off for a long
  // stretch so the pipeline fills and pushes back on the input; otherwise
  // stall at the current idle rate.
  always @(posedge clk_i) begin : rx_stall
    int unsigned hold_left;
    logic        hold_done;
    if (!rst_ni) begin
      hold_left = 0;
      hold_done = 1'b0;
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Note every accepted instruction in transfer order.
  always @(posedge clk_i) begin : in_mon
    tcb_pkg::req_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      r.req_type  = req_type_i;
      r.operand_a = operand_a_i;
      r.operand_b = operand_b_i;
      r.immediate = immediate_i;
      r.condition = condition_i;
      r.pc_value  = pc_value_i;
      sb.note_insn(r);
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : out_mon
    tcb_pkg::res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.flags            = {flag_n_o, flag_z_o, flag_c_o, flag_v_o};
      got.branch_taken     = branch_taken_o;
      got.next_pc          = next_pc_o;
      got.link_write       = link_write_o;
      got.link_value       = link_value_o;
      got.exception_return = exception_return_o;
      got.fault            = fault_o;
      got.cycles           = cycles_o;
      sb.check_result(got);
    end
  end

  function automatic tcb_pkg::req_t mk_insn(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                            logic [23:0] imm, logic [3:0] cond,
                                            logic [31:0] pc);
    tcb_pkg::req_t r;
    r.req_type  = op;
    r.operand_a = a;
    r.operand_b = b;
    r.immediate = imm;
    r.condition = cond;
    r.pc_value  = pc;
    return r;
  endfunction

  // Operand values biased toward the sign and carry boundaries.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic tcb_pkg::req_t rand_insn();
    tcb_pkg::req_t r;
    int unsigned   k;
    k           = $urandom_range(99);
    r.operand_a = pick_word();
    r.operand_b = ($urandom_range(3) == 0) ? r.operand_a : pick_word();
    r.immediate = ($urandom_range(1) == 0) ? 24'($urandom) : 24'($urandom_range(255));
    r.condition = ($urandom_range(9) == 0)
                  ? 4'($urandom_range(14, 15))
                  : 4'($urandom_range(tcb_pkg::COND_EQ, tcb_pkg::COND_LE));
    r.pc_value  = $urandom;
    // conditional branches get extra weight so they see many flag states
    if (k < 6)       r.req_type = 4'($urandom_range(9, 15));
    else if (k < 36) r.req_type = tcb_pkg::REQ_B_COND;
    else             r.req_type = 4'($urandom_range(tcb_pkg::REQ_CMN, tcb_pkg::REQ_BL));
    if (r.req_type == tcb_pkg::REQ_CMP_IMM && $urandom_range(3) == 0) begin
      r.operand_a = {8'd0, r.immediate};
    end
    if (r.req_type == tcb_pkg::REQ_BX || r.req_type == tcb_pkg::REQ_BLX) begin
      k = $urandom_range(99);
      if (k < 15)      r.operand_a[0] = 1'b0;
      else if (k < 40) r.operand_a = {tcb_pkg::EXC_RETURN_NIBBLE, r.operand_a[27:1], 1'b1};
      else             r.operand_a[0] = 1'b1;
    end
    return r;
  endfunction

  // Offer one instruction and hold it until the transfer completes. Idle
  // cycles come first so valid stays high across back-to-back transfers.
  task automatic send_insn(tcb_pkg::req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= r.req_type;
    operand_a_i <= r.operand_a;
    operand_b_i <= r.operand_b;
    immediate_i <= r.immediate;
    condition_i <= r.condition;
    pc_value_i  <= r.pc_value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic run_directed();
    tcb_pkg::req_t seq[$];
    seq.push_back(mk_insn(tcb_pkg::REQ_CMN, 32'hFFFF_FFFF, 32'h1, '0, tcb_pkg::COND_EQ,
                          32'h100));
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'h7F, tcb_pkg::COND_EQ, 32'h200));
    seq.push_back(mk_insn(tcb_pkg::REQ_CMN, 32'h7FFF_FFFF, 32'h1, '0, tcb_pkg::COND_EQ,
                          32'h100));
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'h80, tcb_pkg::COND_LT, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_CMP_IMM, 32'h0, '0, 24'hFF_FFFF, tcb_pkg::COND_EQ,
                          32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_CMP_IMM, 32'h5, '0, 24'h5, tcb_pkg::COND_EQ, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'hFF, tcb_pkg::COND_HI, 32'h1000));
    seq.push_back(mk_insn(tcb_pkg::REQ_CMP_REG, 32'h8000_0000, 32'h1, '0, tcb_pkg::COND_EQ,
                          32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'h01, tcb_pkg::COND_VS,
                          32'hFFFF_FFFE));
    seq.push_back(mk_insn(tcb_pkg::REQ_TST, 32'hFFFF_FFFF, 32'h8000_0000, '0,
                          tcb_pkg::COND_EQ, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_TST, 32'h5555_5555, 32'hAAAA_AAAA, '0,
                          tcb_pkg::COND_EQ, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'h10, tcb_pkg::COND_LE, 32'h40));
    seq.push_back(mk_insn(tcb_pkg::REQ_B, '0, '0, 24'h7FF, tcb_pkg::COND_EQ, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_B, '0, '0, 24'hFF_F3FF, tcb_pkg::COND_EQ,
                          32'hFFFF_FFF0));
    // malformed conditions
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'h10, 4'd14, 32'h80));
    seq.push_back(mk_insn(tcb_pkg::REQ_B_COND, '0, '0, 24'h10, 4'd15, 32'h80));
    // interworking: even targets fault, odd ones branch
    seq.push_back(mk_insn(tcb_pkg::REQ_BLX, 32'h0000_2000, '0, '0, tcb_pkg::COND_EQ,
                          32'h300));
    seq.push_back(mk_insn(tcb_pkg::REQ_BLX, 32'hFFFF_FFFF, '0, '0, tcb_pkg::COND_EQ, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_BX, 32'hFFFF_FFF9, '0, '0, tcb_pkg::COND_EQ, 32'h400));
    seq.push_back(mk_insn(tcb_pkg::REQ_BX, 32'hF000_0000, '0, '0, tcb_pkg::COND_EQ, 32'h400));
    seq.push_back(mk_insn(tcb_pkg::REQ_BX, 32'h0000_0001, '0, '0, tcb_pkg::COND_EQ, 32'h400));
    seq.push_back(mk_insn(tcb_pkg::REQ_BL, '0, '0, 24'hFF_FFFF, tcb_pkg::COND_EQ, 32'h0));
    seq.push_back(mk_insn(tcb_pkg::REQ_BL, '0, '0, 24'h7F_FFFF, tcb_pkg::COND_EQ,
                          32'hFFFF_FFFE));
    // undefined request codes do nothing
    seq.push_back(mk_insn(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 4'd15, 32'h123));
    seq.push_back(mk_insn(4'd15, '0, '0, '0, tcb_pkg::COND_EQ, 32'hFFFF_FFFF));
    foreach (seq[i]) send_insn(seq[i]);
  endtask

  task automatic run_random_phase(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (ITEMS_PER_PHASE) send_insn(rand_insn());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 21;
    rx_idle_pct <= 65;
    run_directed();

    run_random_phase(21, 65);
    run_random_phase(65, 21);
    // no idling at all; the long hold-off starts here
    hold_req <= 1'b1;
    run_random_phase(0, 0);
    in_valid_i <= 1'b0;

    // drain, then give the pipeline time to show any stray result
    while (sb.predicted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d instructions retired, %0d branches taken, %0d with link",
             sb.retired, sb.taken_cnt, sb.link_cnt);
    $display("tb: %0d faults, %0d exception returns, %0d mismatches",
             sb.fault_cnt, sb.exc_ret_cnt, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tcb_pkg.sv
src/tcb_exec.sv
src/thumb_compare_branch_unit.sv
src/tcb_checker.sv
bench/tb.sv
